[sv/assert_macros.svh]
// Assertion macros shared by the steering and traction control RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASTPC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("astpc assertion failed");
`define ASTPC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
    else $error("astpc assertion failed");
`else
`define ASTPC_ASSERT(lbl, clk, rst_n, prop)
`define ASTPC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[sv/astpc_pkg.sv]
// Types and constants for the Ackermann steering / traction controller.
// No dependencies.
package astpc_pkg;

    localparam int unsigned FW     = 24;   // payload field width
    localparam int unsigned RW     = 23;   // register width
    localparam int unsigned ANG_W  = 30;   // CORDIC angle fraction bits
    localparam int unsigned RX_W   = 32;   // rotation CORDIC x/y width
    localparam int unsigned RZ_W   = 33;   // rotation CORDIC angle width
    localparam int unsigned VX_W   = 58;   // vectoring CORDIC x/y width
    localparam int unsigned VZ_W   = 34;   // vectoring CORDIC angle width
    localparam int unsigned MAX_STEPS = 24;

    localparam logic signed [RX_W-1:0] KINV_Q30 = 32'sd652032874;
    localparam logic signed [VZ_W-1:0] PI_Q30   = 34'sd3373259426;

    localparam logic [29:0] ATAN_TAB [MAX_STEPS] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
        30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
        30'd262143,    30'd131071,    30'd65535,     30'd32767,
        30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127
    };

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_SPEED_GAIN   = 3'd0,
        REG_STEER_GAIN   = 3'd1,
        REG_STEER_LIMIT  = 3'd2,
        REG_DRIVE_LIMIT  = 3'd3,
        REG_WHEEL_RADIUS = 3'd4,
        REG_WHEELBASE    = 3'd5,
        REG_HALF_TRACK   = 3'd6,
        REG_UNUSED       = 3'd7
    } t_reg_idx;

    // saturate a wide signed value to a 24-bit signed field
    function automatic logic signed [FW-1:0] sat_s24(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd8388607;
        lo = -64'sd8388608;
        if (v > hi) begin
            sat_s24 = 24'sh7FFFFF;
        end else if (v < lo) begin
            sat_s24 = 24'sh800000;
        end else begin
            sat_s24 = v[FW-1:0];
        end
    endfunction

    // fields carried beside the steering path
    typedef struct packed {
        logic signed [FW-1:0] speed;
        logic                 steer_nz;
        logic signed [FW-1:0] meas_l;
        logic signed [FW-1:0] meas_r;
        logic [3:0][47:0]     wheel_prod;
    } t_side;

    // atan2 pre-rotation info for both wheels
    typedef struct packed {
        logic signed [VZ_W-1:0] base_l;
        logic signed [VZ_W-1:0] base_r;
        logic                   zero_l;
        logic                   zero_r;
    } t_vside;

endpackage

[sv/astpc_if.sv]
// Valid/ready channel interfaces for control ticks and effort results.
// Depends on astpc_pkg.
interface astpc_in_if
    import astpc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic signed [FW-1:0] speed_command;
    logic signed [FW-1:0] steer_command;
    logic signed [FW-1:0] front_left_rate;
    logic signed [FW-1:0] front_right_rate;
    logic signed [FW-1:0] back_left_rate;
    logic signed [FW-1:0] back_right_rate;
    logic signed [FW-1:0] left_steer_angle;
    logic signed [FW-1:0] right_steer_angle;

    modport source (output valid, speed_command, steer_command, front_left_rate,
                    front_right_rate, back_left_rate, back_right_rate,
                    left_steer_angle, right_steer_angle, input ready);
    modport sink (input valid, speed_command, steer_command, front_left_rate,
                  front_right_rate, back_left_rate, back_right_rate,
                  left_steer_angle, right_steer_angle, output ready);
endinterface

interface astpc_out_if
    import astpc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic signed [FW-1:0] left_steer_effort;
    logic signed [FW-1:0] right_steer_effort;
    logic signed [FW-1:0] front_left_effort;
    logic signed [FW-1:0] front_right_effort;
    logic signed [FW-1:0] back_left_effort;
    logic signed [FW-1:0] back_right_effort;

    modport source (output valid, left_steer_effort, right_steer_effort,
                    front_left_effort, front_right_effort, back_left_effort,
                    back_right_effort, input ready);
    modport sink (input valid, left_steer_effort, right_steer_effort,
                  front_left_effort, front_right_effort, back_left_effort,
                  back_right_effort, output ready);
endinterface

[sv/astpc_rot_pipe.sv]
// Pipelined rotation CORDIC: sin and cos of a Q30 angle, one step per stage.
// Depends on astpc_pkg.
module astpc_rot_pipe
    import astpc_pkg::*;
#(
    parameter int unsigned STEPS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [RZ_W-1:0] i_z,
    output logic signed [RX_W-1:0] o_sin,
    output logic signed [RX_W-1:0] o_cos
);
    logic signed [RX_W-1:0] r_x [STEPS];
    logic signed [RX_W-1:0] r_y [STEPS];
    logic signed [RZ_W-1:0] r_z [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_stage
        logic signed [RX_W-1:0] w_x;
        logic signed [RX_W-1:0] w_y;
        logic signed [RZ_W-1:0] w_z;
        logic signed [RZ_W-1:0] w_a;
        if (i == 0) begin : g_first
            assign w_x = KINV_Q30;
            assign w_y = '0;
            assign w_z = i_z;
        end else begin : g_next
            assign w_x = r_x[i-1];
            assign w_y = r_y[i-1];
            assign w_z = r_z[i-1];
        end
        assign w_a = signed'(RZ_W'(ATAN_TAB[i]));

        // one micro-rotation toward zero residual angle
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_z >= 0) begin
                    r_x[i] <= w_x - (w_y >>> i);
                    r_y[i] <= w_y + (w_x >>> i);
                    r_z[i] <= w_z - w_a;
                end else begin
                    r_x[i] <= w_x + (w_y >>> i);
                    r_y[i] <= w_y - (w_x >>> i);
                    r_z[i] <= w_z + w_a;
                end
            end
        end
    end

    assign o_sin = r_y[STEPS-1];
    assign o_cos = r_x[STEPS-1];
endmodule

[sv/astpc_vec_pipe.sv]
// Pipelined vectoring CORDIC: angle of a right half-plane vector in Q30.
// Depends on astpc_pkg.
module astpc_vec_pipe
    import astpc_pkg::*;
#(
    parameter int unsigned STEPS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [VX_W-1:0] i_x,
    input  logic signed [VX_W-1:0] i_y,
    output logic signed [VZ_W-1:0] o_z
);
    logic signed [VX_W-1:0] r_x [STEPS];
    logic signed [VX_W-1:0] r_y [STEPS];
    logic signed [VZ_W-1:0] r_z [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_stage
        logic signed [VX_W-1:0] w_x;
        logic signed [VX_W-1:0] w_y;
        logic signed [VZ_W-1:0] w_z;
        logic signed [VZ_W-1:0] w_a;
        if (i == 0) begin : g_first
            assign w_x = i_x;
            assign w_y = i_y;
            assign w_z = '0;
        end else begin : g_next
            assign w_x = r_x[i-1];
            assign w_y = r_y[i-1];
            assign w_z = r_z[i-1];
        end
        assign w_a = signed'(VZ_W'(ATAN_TAB[i]));

        // rotate y toward zero, accumulate angle
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_y < 0) begin
                    r_x[i] <= w_x - (w_y >>> i);
                    r_y[i] <= w_y + (w_x >>> i);
                    r_z[i] <= w_z - w_a;
                end else begin
                    r_x[i] <= w_x + (w_y >>> i);
                    r_y[i] <= w_y - (w_x >>> i);
                    r_z[i] <= w_z + w_a;
                end
            end
        end
    end

    assign o_z = r_z[STEPS-1];
endmodule

[sv/ackermann_steer_traction_pctrl_unit.sv]
// Ackermann steering and traction proportional controller, top level.
// Throughput: one request per cycle; the pipeline advances as a whole and
// holds every stage while a finished result waits on the output.
// Reset (synchronous, active low) clears all valid bits and loads the
// register defaults; datapath registers are not reset.
`include "assert_macros.svh"
module ackermann_steer_traction_pctrl_unit
    import astpc_pkg::*;
#(
    parameter int unsigned FRAC_BITS    = 16,
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    astpc_in_if.sink          i_req,
    astpc_out_if.source       o_rsp,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [RW-1:0]     i_cfg_data
);
    localparam int unsigned SH = ANG_W - FRAC_BITS;
    localparam int unsigned D  = 2 * CORDIC_STEPS + 3;
    localparam int unsigned LAT = D + 4;
    localparam logic signed [31:0] SPD_LIM = 32'(10 << FRAC_BITS);
    localparam logic signed [31:0] ANG_LIM = 32'(((52 << FRAC_BITS) + 50) / 100);
    // rounding offsets, signed so the following shifts stay arithmetic
    localparam logic signed [34:0] HALF_A = 35'sd1 <<< (SH - 1);
    localparam logic signed [48:0] HALF_F = 49'sd1 <<< (FRAC_BITS - 1);

    // configuration registers
    logic [RW-1:0] r_speed_gain, r_steer_gain, r_steer_lim, r_drive_lim;
    logic [RW-1:0] r_radius, r_wheelbase, r_half_track;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_gain <= 23'd655360;
            r_steer_gain <= 23'd2293760;
            r_steer_lim  <= 23'd655360;
            r_drive_lim  <= 23'd1310720;
            r_radius     <= 23'd9830;
            r_wheelbase  <= 23'd65536;
            r_half_track <= 23'd6881;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_SPEED_GAIN:   r_speed_gain <= i_cfg_data;
                REG_STEER_GAIN:   r_steer_gain <= i_cfg_data;
                REG_STEER_LIMIT:  r_steer_lim  <= i_cfg_data;
                REG_DRIVE_LIMIT:  r_drive_lim  <= i_cfg_data;
                REG_WHEEL_RADIUS: r_radius     <= i_cfg_data;
                REG_WHEELBASE:    r_wheelbase  <= i_cfg_data;
                REG_HALF_TRACK:   r_half_track <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: whole pipe moves unless the output is stalled
    logic             w_adv;
    logic [LAT-1:0]   r_vld;
    assign w_adv       = !r_vld[LAT-1] || o_rsp.ready;
    assign i_req.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_req.valid};
        end
    end

    // stage 0: clamp commands, wheel speed products
    logic signed [FW-1:0]   w_v, w_a;
    logic signed [31:0]     w_v32, w_a32;
    logic signed [47:0]     w_rad;
    t_side                  n_side0;
    t_side                  r_side [D];
    logic signed [RZ_W-1:0] r_z0;

    assign w_v32 = 32'(i_req.speed_command);
    assign w_a32 = 32'(i_req.steer_command);
    assign w_rad = signed'(48'({1'b0, r_radius}));

    always_comb begin
        if (w_v32 > SPD_LIM) begin
            w_v = FW'(SPD_LIM);
        end else if (w_v32 < -SPD_LIM) begin
            w_v = FW'(-SPD_LIM);
        end else begin
            w_v = i_req.speed_command;
        end
        if (w_a32 > ANG_LIM) begin
            w_a = FW'(ANG_LIM);
        end else if (w_a32 < -ANG_LIM) begin
            w_a = FW'(-ANG_LIM);
        end else begin
            w_a = i_req.steer_command;
        end
        n_side0.speed = w_v;
        n_side0.steer_nz = (w_a != '0);
        n_side0.meas_l = i_req.left_steer_angle;
        n_side0.meas_r = i_req.right_steer_angle;
        n_side0.wheel_prod[0] = 48'(48'(i_req.front_left_rate) * w_rad);
        n_side0.wheel_prod[1] = 48'(48'(i_req.front_right_rate) * w_rad);
        n_side0.wheel_prod[2] = 48'(48'(i_req.back_left_rate) * w_rad);
        n_side0.wheel_prod[3] = 48'(48'(i_req.back_right_rate) * w_rad);
    end

    // side fields delay line across the CORDIC stages
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= n_side0;
            r_z0      <= RZ_W'(w_a) <<< SH;
            for (int k = 1; k < D; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // sin / cos of the clamped steering angle
    logic signed [RX_W-1:0] w_sin, w_cos;
    astpc_rot_pipe #(.STEPS(CORDIC_STEPS)) u_rot (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_z   (r_z0),
        .o_sin (w_sin),
        .o_cos (w_cos)
    );

    // stage S1: geometry products
    logic signed [55:0] r_ls, r_lc, r_hs;
    logic signed [55:0] w_l56, w_h56;
    assign w_l56 = signed'(56'({1'b0, r_wheelbase}));
    assign w_h56 = signed'(56'({1'b0, r_half_track}));

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ls <= w_l56 * 56'(w_sin);
            r_lc <= w_l56 * 56'(w_cos);
            r_hs <= w_h56 * 56'(w_sin);
        end
    end

    // stage S2: form both vectors, fold into the right half plane
    logic signed [VX_W-1:0] w_xl, w_xr, w_y;
    logic signed [VX_W-1:0] r_xl, r_xr, r_yl, r_yr;
    t_vside                 n_vs;
    t_vside                 r_vs [CORDIC_STEPS+1];

    assign w_y  = VX_W'(r_ls);
    assign w_xl = VX_W'(r_lc) - VX_W'(r_hs);
    assign w_xr = VX_W'(r_lc) + VX_W'(r_hs);

    always_comb begin
        n_vs.zero_l = (w_xl == '0) && (w_y == '0);
        n_vs.zero_r = (w_xr == '0) && (w_y == '0);
        n_vs.base_l = '0;
        n_vs.base_r = '0;
        if (w_xl < 0) begin
            n_vs.base_l = (w_y >= 0) ? PI_Q30 : -PI_Q30;
        end
        if (w_xr < 0) begin
            n_vs.base_r = (w_y >= 0) ? PI_Q30 : -PI_Q30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_xl     <= (w_xl < 0) ? -w_xl : w_xl;
            r_yl     <= (w_xl < 0) ? -w_y : w_y;
            r_xr     <= (w_xr < 0) ? -w_xr : w_xr;
            r_yr     <= (w_xr < 0) ? -w_y : w_y;
            r_vs[0]  <= n_vs;
            for (int k = 1; k <= CORDIC_STEPS; k++) begin
                r_vs[k] <= r_vs[k-1];
            end
        end
    end

    // atan2 for both wheels
    logic signed [VZ_W-1:0] w_zl, w_zr;
    astpc_vec_pipe #(.STEPS(CORDIC_STEPS)) u_vec_l (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_x   (r_xl),
        .i_y   (r_yl),
        .o_z   (w_zl)
    );
    astpc_vec_pipe #(.STEPS(CORDIC_STEPS)) u_vec_r (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_x   (r_xr),
        .i_y   (r_yr),
        .o_z   (w_zr)
    );

    // stage S3: reference angles to Q.FRAC, wheel speeds rounded
    t_side                  w_sd;
    t_vside                 w_vs;
    logic signed [34:0]     w_ql, w_qr, w_rl, w_rr;
    logic signed [FW-1:0]   r_ref_l, r_ref_r, r_meas_l, r_meas_r, r_speed;
    logic signed [FW-1:0]   r_mps [4];

    assign w_sd = r_side[D-1];
    assign w_vs = r_vs[CORDIC_STEPS];
    assign w_ql = 35'(w_vs.base_l) + 35'(w_zl);
    assign w_qr = 35'(w_vs.base_r) + 35'(w_zr);
    assign w_rl = (w_ql + HALF_A) >>> SH;
    assign w_rr = (w_qr + HALF_A) >>> SH;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ref_l  <= (!w_sd.steer_nz || w_vs.zero_l) ? '0 : sat_s24(64'(w_rl));
            r_ref_r  <= (!w_sd.steer_nz || w_vs.zero_r) ? '0 : sat_s24(64'(w_rr));
            r_meas_l <= w_sd.meas_l;
            r_meas_r <= w_sd.meas_r;
            r_speed  <= w_sd.speed;
            for (int k = 0; k < 4; k++) begin
                r_mps[k] <= sat_s24(64'((49'(signed'(w_sd.wheel_prod[k]))
                            + HALF_F) >>> FRAC_BITS));
            end
        end
    end

    // stage S4: saturated errors (0,1 steering; 2..5 traction)
    logic signed [FW-1:0] r_err [6];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_err[0] <= sat_s24(64'(r_ref_l) - 64'(r_meas_l));
            r_err[1] <= sat_s24(64'(r_ref_r) - 64'(r_meas_r));
            for (int k = 0; k < 4; k++) begin
                r_err[2+k] <= sat_s24(64'(r_speed) - 64'(r_mps[k]));
            end
        end
    end

    // stage S5: gain products
    logic signed [47:0] r_prod [6];
    logic signed [47:0] w_sg, w_dg;
    assign w_sg = signed'(48'({1'b0, r_steer_gain}));
    assign w_dg = signed'(48'({1'b0, r_speed_gain}));
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 6; k++) begin
                r_prod[k] <= 48'(r_err[k]) * ((k < 2) ? w_sg : w_dg);
            end
        end
    end

    // stage S6: round and clamp to effort limits, output register
    logic signed [48:0]   w_u [6];
    logic signed [48:0]   w_lim [6];
    logic signed [FW-1:0] r_eff [6];
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            w_u[k]   = (49'(r_prod[k]) + HALF_F) >>> FRAC_BITS;
            w_lim[k] = signed'(49'((k < 2) ? r_steer_lim : r_drive_lim));
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 6; k++) begin
                if (w_u[k] > w_lim[k]) begin
                    r_eff[k] <= FW'(w_lim[k]);
                end else if (w_u[k] < -w_lim[k]) begin
                    r_eff[k] <= FW'(-w_lim[k]);
                end else begin
                    r_eff[k] <= FW'(w_u[k]);
                end
            end
        end
    end

    assign o_rsp.valid              = r_vld[LAT-1];
    assign o_rsp.left_steer_effort  = r_eff[0];
    assign o_rsp.right_steer_effort = r_eff[1];
    assign o_rsp.front_left_effort  = r_eff[2];
    assign o_rsp.front_right_effort = r_eff[3];
    assign o_rsp.back_left_effort   = r_eff[4];
    assign o_rsp.back_right_effort  = r_eff[5];

    // checks
    `ASTPC_ASSERT_ALWAYS(a_rst_clears, i_clk, !i_rst_n |=> !o_rsp.valid)
    `ASTPC_ASSERT(a_stall_freezes, i_clk, i_rst_n,
        (o_rsp.valid && !o_rsp.ready) |=> $stable(r_vld))
    `ASTPC_ASSERT(a_drive_bound, i_clk, i_rst_n,
        o_rsp.valid |-> (49'(o_rsp.front_left_effort) <= w_lim[2]
                         && 49'(o_rsp.front_left_effort) >= -w_lim[2]))
    `ASTPC_ASSERT(a_steer_bound, i_clk, i_rst_n,
        o_rsp.valid |-> (49'(o_rsp.left_steer_effort) <= w_lim[0]
                         && 49'(o_rsp.left_steer_effort) >= -w_lim[0]))
endmodule
